// File: design/icsc_pkg.sv
// Shared types, codes and identifier tables for the image container structure checker.
package icsc_pkg;

  typedef enum logic [3:0] {
    PH_SIG0, PH_SIGJ, PH_SIGJ3, PH_SIGP, PH_JFF, PH_JMARK, PH_JLHI, PH_JLLO,
    PH_JSKIP, PH_JSKIPSCAN, PH_JSCAN, PH_TAIL, PH_PHDR, PH_PSKIP, PH_PCRC, PH_IGNORE
  } phase_t;

  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_JPEG    = 2'd1;
  localparam logic [1:0] FMT_PNG     = 2'd2;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_EXIF    = 3'd1;
  localparam logic [2:0] CLS_XMP     = 3'd2;
  localparam logic [2:0] CLS_ICC     = 3'd3;
  localparam logic [2:0] CLS_COMMENT = 3'd4;
  localparam logic [2:0] CLS_TEXT    = 3'd5;

  localparam logic [2:0] ST_CLEAN    = 3'd0;
  localparam logic [2:0] ST_TRAILING = 3'd1;
  localparam logic [2:0] ST_NO_IEND  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_ANOMALY  = 3'd4;

  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_APP1 = 8'hE1;
  localparam logic [7:0] MK_APP2 = 8'hE2;
  localparam logic [7:0] MK_COM  = 8'hFE;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;

  localparam logic [31:0] T_EXIF = 32'h65584966;
  localparam logic [31:0] T_TEXT = 32'h74455874;
  localparam logic [31:0] T_ITXT = 32'h69545874;
  localparam logic [31:0] T_ZTXT = 32'h7A545874;
  localparam logic [31:0] T_ICCP = 32'h69434350;
  localparam logic [31:0] T_IEND = 32'h49454E44;

  typedef struct packed {
    logic        kind;
    logic [1:0]  fmt;
    logic [31:0] code;
    logic [31:0] offset;
    logic [31:0] length;
    logic [2:0]  cls;
    logic        meta;
    logic        endf;
    logic [31:0] tail;
    logic [2:0]  status;
    logic        last;
  } result_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] i);
    logic [7:0] v;
    case (i)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] exif_char(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0: v = 8'h45;
      2'd1: v = 8'h78;
      2'd2: v = 8'h69;
      default: v = 8'h66;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] http_char(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0: v = 8'h68;
      2'd1: v = 8'h74;
      2'd2: v = 8'h74;
      default: v = 8'h70;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] icc_char(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0: v = 8'h49;
      4'd1: v = 8'h43;
      4'd2: v = 8'h43;
      4'd3: v = 8'h5F;
      4'd4: v = 8'h50;
      4'd5: v = 8'h52;
      4'd6: v = 8'h4F;
      4'd7: v = 8'h46;
      4'd8: v = 8'h49;
      4'd9: v = 8'h4C;
      default: v = 8'h45;
    endcase
    return v;
  endfunction

endpackage

// File: design/icsc_rfifo.sv
// Four-entry result queue that takes up to two results a cycle and gives one.
module icsc_rfifo
  import icsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output logic       can_take_two,
  output logic       not_empty,
  output result_t    head
);

  result_t    mem_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;
  logic       do_pop;

  assign not_empty    = (cnt_r != 3'd0);
  assign can_take_two = (cnt_r <= 3'd2);
  assign do_pop       = pop && not_empty;
  assign head         = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_r + push_cnt;
      rd_r  <= rd_r + {1'b0, do_pop};
      cnt_r <= cnt_r + {1'b0, push_cnt} - {2'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> can_take_two) else $error("push without room");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && push_cnt == 2'd0) |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("pop did not reduce fill");
`endif

endmodule

// File: design/image_container_structure_checker_core.sv
// Top level of the image container structure checker: byte walker and result queue.
// Takes one file byte per cycle and walks JPEG marker segments or PNG chunks, giving one
// request per segment or chunk header and a final report on the byte flagged last; a byte
// gives at most two results. The parser state registers are updated in the same cycle as
// the byte is taken, and its results go to a four-entry queue. A byte is taken whenever
// the queue has room for two results, so the sustained rate is one byte per cycle while
// the output side takes a result every cycle, and falls to the output rate when bytes give
// more results than are drained.
module image_container_structure_checker_core
  import icsc_pkg::*;
#(
  parameter int OFFSET_BITS = 32
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // file_format, segment_code, segment_offset,
                                   // segment_length, meta_class, metadata_present,
                                   // end_marker_found, trailing_count, report_status
  output logic         out_tuser,  // event_kind
  output logic         out_tlast   // run_last
);

  localparam int WB = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             fmt_r, fmt_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, start_r, start_nxt, poff_r, poff_nxt;
  logic [31:0]            hdr_r, hdr_nxt, len_r, len_nxt, tail_r, tail_nxt;
  logic [32:0]            skip_r, skip_nxt;
  logic [2:0]             ident_r, ident_nxt, hidx_r, hidx_nxt;
  logic [7:0]             prev_r, prev_nxt, pcode_r, pcode_nxt;
  logic [15:0]            plen_r, plen_nxt;
  logic [4:0]             prel_r, prel_nxt, ptgt_r, ptgt_nxt;
  logic                   meta_r, meta_nxt, end_r, end_nxt, anom_r, anom_nxt;
  logic                   pend_r, pend_nxt;

  logic       acc;
  logic [1:0] n_ev;
  result_t    ev0, ev1, head;
  logic       room;

  assign acc = in_tvalid && in_tready;
  assign in_tready = room;

  function automatic logic [31:0] sat_off(input logic [OFFSET_BITS-1:0] v);
    logic [WB-1:0] e;
    e = WB'(v);
    return (e > WB'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : e[31:0];
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  rel, ii;
    logic [2:0]  cls;
    logic [2:0]  st;
    logic [7:0]  mk;
    logic [15:0] jl;
    phase_t      ph;
    result_t     ev [2];
    logic        nidx;

    b = in_tdata; rel = '0; ii = '0; cls = CLS_NONE; st = ST_CLEAN; mk = '0; jl = '0;
    ph = phase_r; ev[0] = '0; ev[1] = '0; nidx = 1'b0;
    phase_nxt = phase_r; fmt_nxt = fmt_r; pos_nxt = pos_r; start_nxt = start_r;
    poff_nxt = poff_r; hdr_nxt = hdr_r; len_nxt = len_r; tail_nxt = tail_r;
    skip_nxt = skip_r; ident_nxt = ident_r; hidx_nxt = hidx_r; prev_nxt = prev_r;
    pcode_nxt = pcode_r; plen_nxt = plen_r; prel_nxt = prel_r; ptgt_nxt = ptgt_r;
    meta_nxt = meta_r; end_nxt = end_r; anom_nxt = anom_r; pend_nxt = pend_r;
    n_ev = 2'd0;

    if (acc) begin
      // Held APP1/APP2 event: match identifier bytes until the decision point.
      if (pend_r) begin
        rel = prel_r + 5'd1;
        prel_nxt = rel;
        if (rel >= 5'd4) begin
          ii = rel - 5'd4;
          if (ii < 5'd4 && b != exif_char(ii[1:0])) ident_nxt[0] = 1'b0;
          if (ii < 5'd4 && b != http_char(ii[1:0])) ident_nxt[1] = 1'b0;
          if (ii < 5'd11 && b != icc_char(ii[3:0])) ident_nxt[2] = 1'b0;
        end
        if (rel == ptgt_r) begin
          cls = CLS_NONE;
          if (ptgt_r == 5'd8) begin
            if (ident_nxt[0]) begin
              cls = CLS_EXIF; meta_nxt = 1'b1;
            end else if (ident_nxt[1]) begin
              cls = CLS_XMP;
            end
          end else if (ident_nxt[2]) begin
            cls = CLS_ICC;
          end
          ev[nidx] = '{kind: 1'b0, fmt: fmt_nxt, code: {24'b0, pcode_r},
                       offset: sat_off(poff_r), length: {16'b0, plen_r}, cls: cls,
                       default: '0};
          nidx = 1'b1; n_ev = 2'd1;
          pend_nxt = 1'b0;
        end
      end

      if (ph == PH_SIGJ3) begin
        fmt_nxt = FMT_JPEG; ph = PH_JFF; phase_nxt = PH_JFF;
      end

      case (ph)
        PH_SIG0: begin
          if (b == 8'hFF) phase_nxt = PH_SIGJ;
          else if (b == 8'h89) phase_nxt = PH_SIGP;
          else phase_nxt = PH_IGNORE;
        end
        PH_SIGJ: phase_nxt = (b == MK_SOI) ? PH_SIGJ3 : PH_IGNORE;
        PH_SIGP: begin
          if (pos_r > OFFSET_BITS'(7) || b != png_sig_byte(pos_r[2:0])) begin
            phase_nxt = PH_IGNORE;
          end else if (pos_r == OFFSET_BITS'(7)) begin
            fmt_nxt = FMT_PNG; phase_nxt = PH_PHDR; hidx_nxt = 3'd0;
          end
        end
        PH_JFF: begin
          if (!in_tlast) begin
            if (b != 8'hFF) begin
              anom_nxt = 1'b1; phase_nxt = PH_IGNORE;
            end else begin
              start_nxt = pos_r; phase_nxt = PH_JMARK;
            end
          end
        end
        PH_JMARK: begin
          if (b == MK_EOI) begin
            end_nxt = 1'b1; phase_nxt = PH_TAIL;
          end else if (b == MK_SOI || (b >= MK_RST0 && b <= MK_RST7) || b == 8'h00) begin
            phase_nxt = PH_JFF;
          end else begin
            hdr_nxt = {24'b0, b}; phase_nxt = PH_JLHI;
          end
        end
        PH_JLHI: begin
          len_nxt = {16'b0, b, 8'b0}; phase_nxt = PH_JLLO;
        end
        PH_JLLO: begin
          jl = {len_r[15:8], b};
          len_nxt = {16'b0, jl};
          mk = hdr_r[7:0];
          if (mk == MK_APP1 && jl >= 16'd6) begin
            pend_nxt = 1'b1; ptgt_nxt = 5'd8; ident_nxt = 3'b011;
            prel_nxt = 5'd3; pcode_nxt = mk; poff_nxt = start_r; plen_nxt = jl;
          end else if (mk == MK_APP2 && jl >= 16'd13) begin
            pend_nxt = 1'b1; ptgt_nxt = 5'd16; ident_nxt = 3'b100;
            prel_nxt = 5'd3; pcode_nxt = mk; poff_nxt = start_r; plen_nxt = jl;
          end else begin
            ev[nidx] = '{kind: 1'b0, fmt: fmt_nxt, code: {24'b0, mk},
                         offset: sat_off(start_r), length: {16'b0, jl},
                         cls: (mk == MK_COM) ? CLS_COMMENT : CLS_NONE, default: '0};
            nidx = 1'b1; n_ev = n_ev + 2'd1;
          end
          if (jl < 16'd2) begin
            anom_nxt = 1'b1; phase_nxt = PH_IGNORE;
          end else begin
            skip_nxt = {17'b0, jl - 16'd2};
            if (mk == MK_SOS) begin
              prev_nxt = 8'h00;
              phase_nxt = (jl != 16'd2) ? PH_JSKIPSCAN : PH_JSCAN;
            end else begin
              phase_nxt = (jl != 16'd2) ? PH_JSKIP : PH_JFF;
            end
          end
        end
        PH_JSKIP: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_r == 33'd1) phase_nxt = PH_JFF;
        end
        PH_JSKIPSCAN: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_r == 33'd1) begin
            prev_nxt = 8'h00; phase_nxt = PH_JSCAN;
          end
        end
        PH_JSCAN: begin
          if (prev_r == 8'hFF && b == MK_EOI) begin
            end_nxt = 1'b1; phase_nxt = PH_TAIL;
          end else begin
            prev_nxt = b;
          end
        end
        PH_TAIL: begin
          if (tail_r != 32'hFFFFFFFF) tail_nxt = tail_r + 32'd1;
        end
        PH_PHDR: begin
          if (hidx_r == 3'd0) start_nxt = pos_r;
          if (hidx_r < 3'd4) len_nxt = {len_r[23:0], b};
          else hdr_nxt = {hdr_r[23:0], b};
          hidx_nxt = hidx_r + 3'd1;
          // Eighth header byte: the chunk type is complete.
          if (hidx_r == 3'd7) begin
            cls = CLS_NONE;
            if (hdr_nxt == T_EXIF) begin
              cls = CLS_EXIF; meta_nxt = 1'b1;
            end else if (hdr_nxt == T_TEXT || hdr_nxt == T_ITXT || hdr_nxt == T_ZTXT) begin
              cls = CLS_TEXT; meta_nxt = 1'b1;
            end else if (hdr_nxt == T_ICCP) begin
              cls = CLS_ICC;
            end
            ev[nidx] = '{kind: 1'b0, fmt: fmt_nxt, code: hdr_nxt,
                         offset: sat_off(start_r), length: len_r, cls: cls, default: '0};
            nidx = 1'b1; n_ev = n_ev + 2'd1;
            if (hdr_nxt == T_IEND) begin
              end_nxt = 1'b1; skip_nxt = 33'd4; phase_nxt = PH_PCRC;
            end else begin
              skip_nxt = {1'b0, len_r} + 33'd4; phase_nxt = PH_PSKIP;
            end
          end
        end
        PH_PSKIP: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_r == 33'd1) begin
            phase_nxt = PH_PHDR; hidx_nxt = 3'd0;
          end
        end
        PH_PCRC: begin
          skip_nxt = skip_r - 33'd1;
          if (skip_r == 33'd1) phase_nxt = PH_TAIL;
        end
        default: ;
      endcase

      if (pos_r != '1) pos_nxt = pos_r + OFFSET_BITS'(1);

      if (in_tlast) begin
        if (pend_nxt) begin
          ev[nidx] = '{kind: 1'b0, fmt: fmt_nxt, code: {24'b0, pcode_nxt},
                       offset: sat_off(poff_nxt), length: {16'b0, plen_nxt},
                       cls: CLS_NONE, default: '0};
          nidx = 1'b1; n_ev = n_ev + 2'd1;
        end
        if (fmt_nxt == FMT_UNKNOWN) st = ST_UNKNOWN;
        else if (anom_nxt) st = ST_ANOMALY;
        else if (end_nxt && tail_nxt != 32'd0) st = ST_TRAILING;
        else if (fmt_nxt == FMT_PNG && !end_nxt) st = ST_NO_IEND;
        else st = ST_CLEAN;
        ev[nidx] = '{kind: 1'b1, fmt: fmt_nxt, meta: meta_nxt, endf: end_nxt,
                     tail: tail_nxt, status: st, default: '0};
        n_ev = n_ev + 2'd1;
        // A new file starts with the next byte.
        phase_nxt = PH_SIG0; fmt_nxt = FMT_UNKNOWN; pos_nxt = '0; start_nxt = '0;
        poff_nxt = '0; hdr_nxt = '0; len_nxt = '0; tail_nxt = '0; skip_nxt = '0;
        ident_nxt = '0; hidx_nxt = '0; prev_nxt = '0; pcode_nxt = '0; plen_nxt = '0;
        prel_nxt = '0; ptgt_nxt = '0; meta_nxt = 1'b0; end_nxt = 1'b0;
        anom_nxt = 1'b0; pend_nxt = 1'b0;
      end
    end

    if (n_ev == 2'd1) ev[0].last = 1'b1;
    if (n_ev == 2'd2) ev[1].last = 1'b1;
    ev0 = ev[0];
    ev1 = ev[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG0; fmt_r <= FMT_UNKNOWN; pos_r <= '0; start_r <= '0;
      poff_r <= '0; hdr_r <= '0; len_r <= '0; tail_r <= '0; skip_r <= '0;
      ident_r <= '0; hidx_r <= '0; prev_r <= '0; pcode_r <= '0; plen_r <= '0;
      prel_r <= '0; ptgt_r <= '0; meta_r <= 1'b0; end_r <= 1'b0;
      anom_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; fmt_r <= fmt_nxt; pos_r <= pos_nxt; start_r <= start_nxt;
      poff_r <= poff_nxt; hdr_r <= hdr_nxt; len_r <= len_nxt; tail_r <= tail_nxt;
      skip_r <= skip_nxt; ident_r <= ident_nxt; hidx_r <= hidx_nxt; prev_r <= prev_nxt;
      pcode_r <= pcode_nxt; plen_r <= plen_nxt; prel_r <= prel_nxt; ptgt_r <= ptgt_nxt;
      meta_r <= meta_nxt; end_r <= end_nxt; anom_r <= anom_nxt; pend_r <= pend_nxt;
    end
  end

  icsc_rfifo u_rfifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_cnt     (n_ev),
    .push0        (ev0),
    .push1        (ev1),
    .pop          (out_tready),
    .can_take_two (room),
    .not_empty    (out_tvalid),
    .head         (head)
  );

  assign out_tuser = head.kind;
  assign out_tlast = head.last;
  assign out_tdata = {6'b0, head.status, head.tail, head.endf, head.meta, head.cls,
                      head.length, head.offset, head.code, head.fmt};

`ifndef SYNTHESIS
  a_last_gives_report: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |-> (n_ev != 2'd0)) else $error("last byte without report");
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (phase_r == PH_SIG0 && !pend_r && fmt_r == FMT_UNKNOWN))
    else $error("walker not restarted after last byte");
  a_hold_window: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (prel_r < ptgt_r)) else $error("held event past its decision point");
`endif

endmodule

// File: verif/image_container_structure_checker_core_tb.sv
// Self-checking testbench for the image container structure checker core.
`timescale 1ns / 1ps

module image_container_structure_checker_core_tb;
  import icsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_BYTES   = 600;
  localparam int CALM_TAIL      = 80;

  // APP2 colour profile identifier.
  localparam string COLOUR_ID = {"ICC_", "PROFILE"};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;   // format, code, offset, length, class, meta, end, tail, status
  logic         out_tuser;   // event_kind
  logic         out_tlast;   // run_last

  image_container_structure_checker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walker state of the predictor.
  logic [1:0]  w_fmt;
  phase_t      w_phase;
  logic [31:0] w_pos, w_seg_start, w_hshift, w_len, w_tail;
  logic [32:0] w_skip;
  logic [3:0]  w_ident;
  logic [7:0]  w_prev;
  logic        w_meta, w_end, w_anom, w_pend;
  logic [7:0]  w_hdr_idx, w_pend_rel, w_pend_target;
  logic [31:0] w_pend_code, w_pend_len, w_pend_off;

  result_t expected_results[$];
  result_t byte_results[$];
  int      errors = 0;
  int      accepted_bytes = 0;
  int      idle_count = 0;
  bit      calm = 1'b0;
  bit      hold_request = 1'b0;
  bit      stim_done = 1'b0;
  logic [7:0] file_bytes[$];

  function automatic void walker_reset();
    w_fmt = FMT_UNKNOWN; w_phase = PH_SIG0; w_pos = '0; w_seg_start = '0;
    w_hshift = '0; w_len = '0; w_tail = '0; w_skip = '0; w_ident = '0; w_prev = '0;
    w_meta = 1'b0; w_end = 1'b0; w_anom = 1'b0; w_pend = 1'b0;
    w_hdr_idx = '0; w_pend_rel = '0; w_pend_target = '0;
    w_pend_code = '0; w_pend_len = '0; w_pend_off = '0;
  endfunction

  function automatic void emit(logic kind, logic [31:0] code, logic [31:0] off,
                               logic [31:0] len, logic [2:0] cls, logic meta,
                               logic endf, logic [31:0] tail, logic [2:0] status);
    result_t r;
    r.kind = kind; r.fmt = w_fmt; r.code = code; r.offset = off; r.length = len;
    r.cls = cls; r.meta = meta; r.endf = endf; r.tail = tail; r.status = status;
    r.last = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void segment_found(logic [31:0] code, logic [31:0] off,
                                        logic [31:0] len, logic [2:0] cls);
    emit(1'b0, code, off, len, cls, 1'b0, 1'b0, '0, ST_CLEAN);
  endfunction

  function automatic void held_identifier_byte(logic [7:0] b);
    string exif_id, http_id, colour_id;
    int i;
    logic [2:0] cls;
    exif_id = "Exif"; http_id = "http"; colour_id = COLOUR_ID;
    cls = CLS_NONE;
    w_pend_rel++;
    if (w_pend_rel >= 4) begin
      i = w_pend_rel - 4;
      if (i < 4 && b != exif_id[i]) w_ident[0] = 1'b0;
      if (i < 4 && b != http_id[i]) w_ident[1] = 1'b0;
      if (i < 11 && b != colour_id[i]) w_ident[2] = 1'b0;
    end
    if (w_pend_rel == w_pend_target) begin
      if (w_pend_target == 8) begin
        if (w_ident[0]) begin
          cls = CLS_EXIF; w_meta = 1'b1;
        end else if (w_ident[1]) cls = CLS_XMP;
      end else if (w_ident[2]) cls = CLS_ICC;
      segment_found(w_pend_code, w_pend_off, w_pend_len, cls);
      w_pend = 1'b0;
    end
  endfunction

  function automatic void jpeg_header_complete();
    logic [7:0] mk;
    logic [2:0] cls;
    bit hold;
    mk = w_hshift[7:0]; cls = CLS_NONE; hold = 0;
    if (mk == MK_APP1 && w_len >= 6) begin
      hold = 1; w_pend_target = 8; w_ident = 4'd3;
    end else if (mk == MK_APP2 && w_len >= 13) begin
      hold = 1; w_pend_target = 16; w_ident = 4'd4;
    end else if (mk == MK_COM) cls = CLS_COMMENT;
    if (hold) begin
      w_pend = 1'b1; w_pend_rel = 8'd3;
      w_pend_code = {24'd0, mk}; w_pend_off = w_seg_start; w_pend_len = w_len;
    end else segment_found({24'd0, mk}, w_seg_start, w_len, cls);
    if (w_len < 2) begin
      w_anom = 1'b1; w_phase = PH_IGNORE;
      return;
    end
    w_skip = {1'b0, w_len} - 33'd2;
    if (mk == MK_SOS) begin
      w_prev = '0;
      w_phase = (w_skip != 0) ? PH_JSKIPSCAN : PH_JSCAN;
    end else w_phase = (w_skip != 0) ? PH_JSKIP : PH_JFF;
  endfunction

  function automatic void png_header_complete();
    logic [2:0] cls;
    cls = CLS_NONE;
    if (w_hshift == T_EXIF) begin
      cls = CLS_EXIF; w_meta = 1'b1;
    end else if (w_hshift == T_TEXT || w_hshift == T_ITXT || w_hshift == T_ZTXT) begin
      cls = CLS_TEXT; w_meta = 1'b1;
    end else if (w_hshift == T_ICCP) cls = CLS_ICC;
    segment_found(w_hshift, w_seg_start, w_len, cls);
    if (w_hshift == T_IEND) begin
      w_end = 1'b1; w_skip = 33'd4; w_phase = PH_PCRC;
    end else begin
      w_skip = {1'b0, w_len} + 33'd4; w_phase = PH_PSKIP;
    end
  endfunction

  // Works out the results that one accepted byte causes and queues them.
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [31:0] p;
    logic [7:0]  sig [8];
    logic [2:0]  status;
    sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    p = w_pos;
    byte_results.delete();
    if (w_pend) held_identifier_byte(b);
    if (w_phase == PH_SIGJ3) begin
      w_fmt = FMT_JPEG; w_phase = PH_JFF;
    end
    case (w_phase)
      PH_SIG0: begin
        if (b == 8'hFF) w_phase = PH_SIGJ;
        else if (b == 8'h89) w_phase = PH_SIGP;
        else w_phase = PH_IGNORE;
      end
      PH_SIGJ: w_phase = (b == MK_SOI) ? PH_SIGJ3 : PH_IGNORE;
      PH_SIGP: begin
        if (p > 7 || b != sig[p[2:0]]) w_phase = PH_IGNORE;
        else if (p == 7) begin
          w_fmt = FMT_PNG; w_phase = PH_PHDR; w_hdr_idx = '0;
        end
      end
      PH_JFF: begin
        if (!last) begin
          if (b != 8'hFF) begin
            w_anom = 1'b1; w_phase = PH_IGNORE;
          end else begin
            w_seg_start = p; w_phase = PH_JMARK;
          end
        end
      end
      PH_JMARK: begin
        if (b == MK_EOI) begin
          w_end = 1'b1; w_phase = PH_TAIL;
        end else if (b == MK_SOI || (b >= MK_RST0 && b <= MK_RST7) || b == 8'h00)
          w_phase = PH_JFF;
        else begin
          w_hshift = {24'd0, b}; w_phase = PH_JLHI;
        end
      end
      PH_JLHI: begin
        w_len = {16'd0, b, 8'd0}; w_phase = PH_JLLO;
      end
      PH_JLLO: begin
        w_len = w_len | {24'd0, b};
        jpeg_header_complete();
      end
      PH_JSKIP: begin
        w_skip--;
        if (w_skip == 0) w_phase = PH_JFF;
      end
      PH_JSKIPSCAN: begin
        w_skip--;
        if (w_skip == 0) begin
          w_prev = '0; w_phase = PH_JSCAN;
        end
      end
      PH_JSCAN: begin
        if (w_prev == 8'hFF && b == MK_EOI) begin
          w_end = 1'b1; w_phase = PH_TAIL;
        end else w_prev = b;
      end
      PH_TAIL: if (w_tail != 32'hFFFF_FFFF) w_tail++;
      PH_PHDR: begin
        if (w_hdr_idx == 0) w_seg_start = p;
        if (w_hdr_idx < 4) w_len = {w_len[23:0], b};
        else w_hshift = {w_hshift[23:0], b};
        w_hdr_idx++;
        if (w_hdr_idx >= 8) begin
          w_hdr_idx = '0;
          png_header_complete();
        end
      end
      PH_PSKIP: begin
        w_skip--;
        if (w_skip == 0) begin
          w_phase = PH_PHDR; w_hdr_idx = '0;
        end
      end
      PH_PCRC: begin
        w_skip--;
        if (w_skip == 0) w_phase = PH_TAIL;
      end
      default: ;
    endcase
    if (w_pos != 32'hFFFF_FFFF) w_pos++;
    if (last) begin
      if (w_pend) begin
        segment_found(w_pend_code, w_pend_off, w_pend_len, CLS_NONE);
        w_pend = 1'b0;
      end
      if (w_fmt == FMT_UNKNOWN) status = ST_UNKNOWN;
      else if (w_anom) status = ST_ANOMALY;
      else if (w_end && w_tail != 0) status = ST_TRAILING;
      else if (w_fmt == FMT_PNG && !w_end) status = ST_NO_IEND;
      else status = ST_CLEAN;
      emit(1'b1, '0, '0, '0, CLS_NONE, w_meta, w_end, w_tail, status);
      walker_reset();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[k]) expected_results.push_back(byte_results[k]);
  endfunction

  // Offers one byte and waits until the block takes it; random gaps before it.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    predict_byte(b, last);
    accepted_bytes++;
    @(negedge clk);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic push_random(int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_jpeg();
    int len, kind;
    bit scanned;
    scanned = 0;
    file_bytes.push_back(8'hFF); file_bytes.push_back(MK_SOI);
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(0, 12);
      file_bytes.push_back(8'hFF);
      case (kind)
        0: file_bytes.push_back(8'(MK_RST0 + $urandom_range(0, 7)));
        1: file_bytes.push_back($urandom_range(0, 1) ? MK_SOI : 8'h00);
        2, 3: begin
          len = $urandom_range(2, 14);
          file_bytes.push_back(MK_APP1); file_bytes.push_back(8'h00);
          file_bytes.push_back(8'(len));
          case ($urandom_range(0, 2))
            0: push_text("Exif");
            1: push_text("http");
            default: push_random(4);
          endcase
          if (len >= 6) push_random(len - 6);
        end
        4, 5: begin
          len = $urandom_range(2, 20);
          file_bytes.push_back(MK_APP2); file_bytes.push_back(8'h00);
          file_bytes.push_back(8'(len));
          if ($urandom_range(0, 2) != 0) push_text(COLOUR_ID);
          else push_random(11);
          if (len >= 13) push_random(len - 13);
        end
        6: begin
          len = $urandom_range(2, 6);
          file_bytes.push_back(MK_COM); file_bytes.push_back(8'h00);
          file_bytes.push_back(8'(len));
          push_random(len - 2);
        end
        7, 8: begin
          len = $urandom_range(2, 6);
          file_bytes.push_back(8'($urandom_range(8'hC0, 8'hEF)));
          file_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
          file_bytes.push_back(8'(len));
          push_random(len - 2);
        end
        9, 10: if (!scanned) begin
          len = $urandom_range(2, 5);
          file_bytes.push_back(MK_SOS); file_bytes.push_back(8'h00);
          file_bytes.push_back(8'(len));
          push_random(len - 2);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 3) == 0) begin
              file_bytes.push_back(8'hFF); file_bytes.push_back(8'h00);
            end else file_bytes.push_back(8'($urandom_range(0, 254)));
          end
          file_bytes.push_back(8'hFF); file_bytes.push_back(MK_EOI);
          scanned = 1;
        end else file_bytes.push_back(MK_RST7);
        11: begin
          file_bytes.push_back(8'hC4); file_bytes.push_back(8'h00);
          file_bytes.push_back(8'($urandom_range(0, 1)));
        end
        default: file_bytes[file_bytes.size() - 1] = 8'($urandom_range(0, 254));
      endcase
    end
    if (!scanned) begin
      file_bytes.push_back(8'hFF); file_bytes.push_back(MK_EOI);
    end
    push_random($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
  endtask

  task automatic build_png();
    logic [31:0] types [7];
    logic [31:0] t;
    logic [7:0]  sig [8];
    int len;
    types = '{T_EXIF, T_TEXT, T_ITXT, T_ZTXT, T_ICCP, 32'h49484452, 32'h49444154};
    sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    foreach (sig[i]) file_bytes.push_back(sig[i]);
    repeat ($urandom_range(1, 3)) begin
      len = $urandom_range(0, 6);
      t = ($urandom_range(0, 4) == 0) ? $urandom() : types[$urandom_range(0, 6)];
      file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00); file_bytes.push_back(8'(len));
      for (int i = 3; i >= 0; i--) file_bytes.push_back(t[i*8 +: 8]);
      push_random(len + 4);
    end
    if ($urandom_range(0, 5) != 0) begin
      file_bytes.push_back(8'($urandom_range(0, 255))); push_random(3);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(T_IEND[i*8 +: 8]);
      push_random(4);
      push_random($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    end
  endtask

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    logic [2:0] status;
  } directed_row_t;

  directed_row_t directed [26] = '{
    '{8'h00, 1, 1, ST_UNKNOWN},
    '{8'hFF, 0, 0, ST_CLEAN}, '{8'hD8, 0, 0, ST_CLEAN}, '{8'hFF, 0, 0, ST_CLEAN},
    '{8'hD9, 1, 1, ST_CLEAN},
    '{8'hFF, 0, 0, ST_CLEAN}, '{8'hD8, 0, 0, ST_CLEAN}, '{8'hFF, 0, 0, ST_CLEAN},
    '{8'hFE, 0, 0, ST_CLEAN}, '{8'h00, 0, 0, ST_CLEAN}, '{8'h02, 0, 0, ST_CLEAN},
    '{8'hFF, 0, 0, ST_CLEAN}, '{8'hD9, 0, 0, ST_CLEAN}, '{8'hFF, 1, 1, ST_TRAILING},
    '{8'hFF, 0, 0, ST_CLEAN}, '{8'hD8, 0, 0, ST_CLEAN}, '{8'h00, 0, 0, ST_CLEAN},
    '{8'h00, 1, 1, ST_ANOMALY},
    '{8'h89, 0, 0, ST_CLEAN}, '{8'h50, 0, 0, ST_CLEAN}, '{8'h4E, 0, 0, ST_CLEAN},
    '{8'h47, 0, 0, ST_CLEAN}, '{8'h0D, 0, 0, ST_CLEAN}, '{8'h0A, 0, 0, ST_CLEAN},
    '{8'h1A, 0, 0, ST_CLEAN}, '{8'h0A, 1, 1, ST_NO_IEND}
  };

  // Stimulus.
  initial begin
    int sent;
    walker_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      send_byte(directed[i].data, directed[i].last);
      if (directed[i].typed &&
          expected_results[expected_results.size() - 1].status != directed[i].status) begin
        $error("directed report_status: expected %0d, predicted %0d", directed[i].status,
               expected_results[expected_results.size() - 1].status);
        errors++;
      end
    end
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      file_bytes.delete();
      case ($urandom_range(0, 9))
        0: push_random($urandom_range(1, 6));
        1, 2, 3, 4, 5: build_jpeg();
        default: build_png();
      endcase
      if ($urandom_range(0, 6) == 0)
        while (file_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(file_bytes.pop_back());
      if (sent > 200) hold_request = 1'b1;
      if (sent > RANDOM_BYTES - CALM_TAIL) calm = 1'b1;
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      sent += file_bytes.size();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls and one long hold-off while bytes keep coming.
  initial begin
    int gap;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end else out_tready <= 1'b1;
    end
  end

  // Compare each result taken with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_tuser !== e.kind) begin
          $error("event_kind: expected %0h, actual %0h", e.kind, out_tuser); errors++;
        end
        if (out_tdata[1:0] !== e.fmt) begin
          $error("file_format: expected %0h, actual %0h", e.fmt, out_tdata[1:0]); errors++;
        end
        if (out_tdata[33:2] !== e.code) begin
          $error("segment_code: expected %0h, actual %0h", e.code, out_tdata[33:2]);
          errors++;
        end
        if (out_tdata[65:34] !== e.offset) begin
          $error("segment_offset: expected %0h, actual %0h", e.offset, out_tdata[65:34]);
          errors++;
        end
        if (out_tdata[97:66] !== e.length) begin
          $error("segment_length: expected %0h, actual %0h", e.length, out_tdata[97:66]);
          errors++;
        end
        if (out_tdata[100:98] !== e.cls) begin
          $error("meta_class: expected %0h, actual %0h", e.cls, out_tdata[100:98]);
          errors++;
        end
        if (out_tdata[101] !== e.meta) begin
          $error("metadata_present: expected %0h, actual %0h", e.meta, out_tdata[101]);
          errors++;
        end
        if (out_tdata[102] !== e.endf) begin
          $error("end_marker_found: expected %0h, actual %0h", e.endf, out_tdata[102]);
          errors++;
        end
        if (out_tdata[134:103] !== e.tail) begin
          $error("trailing_count: expected %0h, actual %0h", e.tail, out_tdata[134:103]);
          errors++;
        end
        if (out_tdata[137:135] !== e.status) begin
          $error("report_status: expected %0h, actual %0h", e.status, out_tdata[137:135]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("run_last: expected %0h, actual %0h", e.last, out_tlast); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any request moving.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
